// File: src/escaped_frame_receiver_pingpong_unit_macros.svh
// Assertion macros for the checker file of the deframer.
`ifndef ESCAPED_FRAME_RECEIVER_PINGPONG_UNIT_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_PINGPONG_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: src/efr_pkg.sv
// Package with the shared types and constants of the deframer.
`default_nettype none
package efr_pkg;
    localparam int MAX_PAYLOAD_DEF = 63;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 6;
    localparam int Q_DEPTH         = 2;

    localparam logic [BYTE_W-1:0] CODE_END   = 8'hFF;
    localparam logic [BYTE_W-1:0] CODE_ESC   = 8'hFE;
    localparam logic [BYTE_W-1:0] HEAD_LIMIT = 8'd63;
    localparam logic [BYTE_W-1:0] ESC_OFFSET = 8'd2;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // One fetch as handed from the front to the back.
    typedef struct packed {
        logic             found;
        logic             buf_sel;
        logic [LEN_W-1:0] len;
    } t_fetch_cmd;

    // What the front needs to know before it takes another fetch.
    typedef struct packed {
        logic q_empty;
        logic back_idle;
    } t_drain_status;
endpackage
`default_nettype wire

// File: src/efr_if.sv
// Handshake interfaces for the line-byte input and the packet-word output.
`default_nettype none
interface efr_in_if;
    import efr_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface efr_out_if;
    import efr_pkg::*;
    logic              valid;
    logic              ready;
    logic              packet_found;
    logic [LEN_W-1:0]  packet_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, packet_found, packet_length, payload_byte, byte_index, last,
                    input ready);
    modport sink   (input valid, packet_found, packet_length, payload_byte, byte_index, last,
                    output ready);
endinterface
`default_nettype wire

// File: src/escaped_frame_receiver_pingpong_unit.sv
// Top level of the byte-stuffed frame deframer with two ping-pong packet buffers.
`default_nettype none
// Line bytes (action 0) are taken one per cycle with no result; 0xFF ends a frame,
// 0xFE escapes the next byte, an escaped value up to MAX_PAYLOAD opens a frame of
// that length. A fetch (action 1) releases the buffer the consumer holds, claims a
// finished packet if there is one and streams it as one word per payload byte, or
// a single closing word when there is no packet or it is empty. Each payload byte
// goes through the registered RAM read and then the output register, one byte at
// a time; a closing-only fetch loads the output register directly. A further fetch is
// held off until the previous fetch has been fully handed to the output register,
// while line bytes keep flowing into the other buffer. The buffer RAM has no reset
// and needs no clearing pass; the block takes items right after reset.
module escaped_frame_receiver_pingpong_unit #(
    parameter int MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efr_in_if.sink    i_rx,
    efr_out_if.source o_pkt
);
    import efr_pkg::*;

    localparam int DEPTH = 2 * MAX_PAYLOAD;
    localparam int AW    = $clog2(DEPTH);

    t_fetch_cmd        push_cmd;
    t_fetch_cmd        head_cmd;
    t_drain_status     drain;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              back_idle;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign drain.q_empty   = q_empty;
    assign drain.back_idle = back_idle;

    efr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_drain   (drain),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    efr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    efr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    efr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_idle    (back_idle),
        .o_pkt     (o_pkt)
    );
endmodule
`default_nettype wire

// File: src/efr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 126
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// File: src/efr_fifo.sv
// Short queue of fetch commands between the front and the back.
`default_nettype none
module efr_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire efr_pkg::t_fetch_cmd i_cmd,
    input  wire logic               i_pop,
    output efr_pkg::t_fetch_cmd     o_cmd,
    output logic                    o_empty
);
    import efr_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_fetch_cmd      r_slot [Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] ptr);
        f_next = (ptr == AW'(Q_DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wr_ptr] <= i_cmd;
                r_wr_ptr         <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: src/efr_front.sv
// Front end: takes line bytes and fetches, runs the frame parser, fills the buffers.
`default_nettype none
module efr_front #(
    parameter int MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF,
    parameter int AW          = $clog2(2 * MAX_PAYLOAD)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    efr_in_if.sink                     i_rx,
    input  wire efr_pkg::t_drain_status i_drain,
    output logic                       o_push,
    output efr_pkg::t_fetch_cmd        o_cmd,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [efr_pkg::BYTE_W-1:0] o_wr_data
);
    import efr_pkg::*;

    typedef enum logic [1:0] {RX_IDLE, RX_RECV, RX_DONE} t_rx_state;

    t_rx_state        r_state, n_state;
    logic             r_esc, n_esc;
    logic             r_load, n_load;
    logic             r_wait, n_wait;
    logic             r_holds, n_holds;
    logic [LEN_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len0, n_len0;
    logic [LEN_W-1:0] r_len1, n_len1;

    logic             accept;
    logic [LEN_W-1:0] cur_len;
    logic             is_header;
    logic             is_data;
    logic             data_ok;
    logic             found;
    logic             new_load;
    logic [BYTE_W-1:0] rx;

    // A fetch waits until the previous one has fully drained, so the buffer being
    // streamed is never the one being loaded.
    assign i_rx.ready = (i_rx.action == ACT_BYTE) || (i_drain.q_empty && i_drain.back_idle);
    assign accept     = i_rx.valid && i_rx.ready;
    assign rx         = i_rx.rx_byte;
    assign cur_len    = r_load ? r_len1 : r_len0;

    assign is_header = r_esc && (rx != CODE_END) && (rx != CODE_ESC) && (rx <= HEAD_LIMIT);
    assign is_data   = (rx != CODE_END) && (rx != CODE_ESC) && !is_header;
    assign data_ok   = (r_state == RX_RECV) && (r_count < cur_len)
                       && (r_count < LEN_W'(MAX_PAYLOAD));

    assign o_wr_addr = (r_load ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(r_count);
    assign o_wr_data = r_esc ? rx + ESC_OFFSET : rx;

    always_comb begin
        n_state  = r_state;
        n_esc    = r_esc;
        n_load   = r_load;
        n_wait   = r_wait;
        n_holds  = r_holds;
        n_count  = r_count;
        n_len0   = r_len0;
        n_len1   = r_len1;
        o_wr_en  = 1'b0;
        o_push   = 1'b0;
        found    = 1'b0;
        new_load = r_load;

        if (accept && i_rx.action == ACT_BYTE) begin
            if (rx == CODE_END) begin
                if (r_state == RX_RECV && r_count == cur_len) begin
                    if (!r_holds) begin
                        n_load  = ~r_load;
                        n_wait  = 1'b1;
                        n_state = RX_IDLE;
                    end else begin
                        n_state = RX_DONE;
                    end
                end else begin
                    n_state = RX_IDLE;
                end
            end else if (rx == CODE_ESC) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (is_header) begin
                    if (r_state == RX_IDLE && rx <= BYTE_W'(MAX_PAYLOAD)) begin
                        if (r_load) begin
                            n_len1 = rx[LEN_W-1:0];
                        end else begin
                            n_len0 = rx[LEN_W-1:0];
                        end
                        n_state = RX_RECV;
                        n_count = '0;
                    end
                end else if (is_data) begin
                    if (data_ok) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + LEN_W'(1);
                    end else begin
                        n_state = RX_IDLE;
                    end
                end
            end
        end else if (accept) begin
            n_holds = 1'b0;
            if (r_wait) begin
                n_wait  = 1'b0;
                n_holds = 1'b1;
                found   = 1'b1;
            end else if (r_state == RX_DONE) begin
                new_load = ~r_load;
                n_state  = RX_IDLE;
                n_holds  = 1'b1;
                found    = 1'b1;
            end
            n_load = new_load;
            o_push = 1'b1;
        end

        o_cmd.found   = found;
        o_cmd.buf_sel = ~new_load;
        o_cmd.len     = found ? (new_load ? r_len0 : r_len1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_IDLE;
            r_esc   <= 1'b0;
            r_load  <= 1'b0;
            r_wait  <= 1'b0;
            r_holds <= 1'b0;
            r_count <= '0;
            r_len0  <= '0;
            r_len1  <= '0;
        end else begin
            r_state <= n_state;
            r_esc   <= n_esc;
            r_load  <= n_load;
            r_wait  <= n_wait;
            r_holds <= n_holds;
            r_count <= n_count;
            r_len0  <= n_len0;
            r_len1  <= n_len1;
        end
    end
endmodule
`default_nettype wire

// File: src/efr_back.sv
// Back end: executes fetch commands and streams packet words from the buffer RAM.
`default_nettype none
module efr_back #(
    parameter int MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF,
    parameter int AW          = $clog2(2 * MAX_PAYLOAD)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire efr_pkg::t_fetch_cmd   i_cmd,
    input  wire logic                  i_q_empty,
    output logic                       o_pop,
    output logic [AW-1:0]              o_rd_addr,
    input  wire logic [efr_pkg::BYTE_W-1:0] i_rd_data,
    output logic                       o_idle,
    efr_out_if.source                  o_pkt
);
    import efr_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_READ, B_SHOW} t_back_state;

    t_back_state       r_state;
    logic              r_buf;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_idx;
    logic              r_valid;
    logic              r_found;
    logic [LEN_W-1:0]  r_length;
    logic [BYTE_W-1:0] r_payload;
    logic [LEN_W-1:0]  r_index;
    logic              r_last;
    logic              out_free;
    logic              idx_last;
    logic              load_out;

    assign out_free  = !r_valid || o_pkt.ready;
    assign o_pop     = (r_state == B_IDLE) && !i_q_empty && out_free;
    assign o_idle    = (r_state == B_IDLE);
    assign o_rd_addr = (r_buf ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(r_idx);
    assign idx_last  = (r_idx + LEN_W'(1)) == r_len;

    // The output register takes a new word either for a closing-only fetch or for
    // a payload byte that has just come out of the RAM.
    assign load_out  = (o_pop && (!i_cmd.found || i_cmd.len == '0))
                       || ((r_state == B_SHOW) && out_free);

    assign o_pkt.valid         = r_valid;
    assign o_pkt.packet_found  = r_found;
    assign o_pkt.packet_length = r_length;
    assign o_pkt.payload_byte  = r_payload;
    assign o_pkt.byte_index    = r_index;
    assign o_pkt.last          = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (r_valid && o_pkt.ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_buf <= i_cmd.buf_sel;
                        r_len <= i_cmd.len;
                        r_idx <= '0;
                        if (!i_cmd.found || i_cmd.len == '0) begin
                            // No packet, or an empty one: a single closing word.
                            r_found   <= i_cmd.found;
                            r_length  <= '0;
                            r_payload <= '0;
                            r_index   <= '0;
                            r_last    <= 1'b1;
                        end else begin
                            r_state <= B_READ;
                        end
                    end
                end
                B_READ: begin
                    r_state <= B_SHOW;
                end
                B_SHOW: begin
                    if (out_free) begin
                        r_found   <= 1'b1;
                        r_length  <= r_len;
                        r_payload <= i_rd_data;
                        r_index   <= r_idx;
                        r_last    <= idx_last;
                        if (idx_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_idx   <= r_idx + LEN_W'(1);
                            r_state <= B_READ;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/efr_checker.sv
// Port-level checker for the deframer output, bound to the top level.
`default_nettype none
`include "escaped_frame_receiver_pingpong_unit_macros.svh"
module efr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic                       i_packet_found,
    input wire logic [efr_pkg::LEN_W-1:0]  i_packet_length,
    input wire logic [efr_pkg::BYTE_W-1:0] i_payload_byte,
    input wire logic [efr_pkg::LEN_W-1:0]  i_byte_index,
    input wire logic                       i_last
);
    import efr_pkg::*;

    // A stalled word keeps its contents.
    `EFR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_payload_byte) && $stable(i_byte_index) && $stable(i_last))

    // A fetch that finds nothing gives one all-zero closing word.
    `EFR_ASSERT_NOW(a_none_word, i_clk, i_rst_n, i_out_valid && !i_packet_found, i_last && i_packet_length == '0 && i_byte_index == '0 && i_payload_byte == '0)

    // Within a packet the index stays below the length.
    `EFR_ASSERT_NOW(a_index_range, i_clk, i_rst_n, i_out_valid && i_packet_found && i_packet_length != '0, i_byte_index < i_packet_length)

    // The closing word of a packet is the one at its final position.
    `EFR_ASSERT_NOW(a_last_pos, i_clk, i_rst_n, i_out_valid && i_packet_found && i_packet_length != '0, i_last == ((i_byte_index + LEN_W'(1)) == i_packet_length))
endmodule

bind escaped_frame_receiver_pingpong_unit efr_checker u_efr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_pkt.valid),
    .i_out_ready     (o_pkt.ready),
    .i_packet_found  (o_pkt.packet_found),
    .i_packet_length (o_pkt.packet_length),
    .i_payload_byte  (o_pkt.payload_byte),
    .i_byte_index    (o_pkt.byte_index),
    .i_last          (o_pkt.last)
);
`default_nettype wire

// File: tb/escaped_frame_receiver_pingpong_unit_tb.sv
// Self-checking testbench for the byte-stuffed frame deframer with ping-pong buffers.
`timescale 1ns / 1ps
module escaped_frame_receiver_pingpong_unit_tb;
    import efr_pkg::*;

    localparam int             MAXP     = 63;
    localparam logic [7:0]     CNT_IDLE = 8'hFF;
    localparam logic [7:0]     CNT_DONE = 8'hA0;
    localparam int             N_RANDOM = 200;

    typedef struct packed {
        logic       act;
        logic [7:0] rx_val;
        logic       hold;
    } line_item_t;

    typedef struct packed {
        logic       found;
        logic [5:0] plen;
        logic [7:0] pbyte;
        logic [5:0] pidx;
        logic       last;
    } pkt_word_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    efr_in_if  rx_if ();
    efr_out_if pkt_if ();

    escaped_frame_receiver_pingpong_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_pkt   (pkt_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    line_item_t line_q[$];
    pkt_word_t  fetch_word_q[$];
    int         mismatch_cnt = 0;

    // Predicted deframer state.
    logic       esc_pend   = 1'b0;
    logic       load_sel   = 1'b0;
    logic [7:0] rcv_cnt    = CNT_IDLE;
    logic       pkt_ready  = 1'b0;
    logic       cons_holds = 1'b0;
    logic [5:0] len_mem [2];
    logic [7:0] byte_mem [0:2*MAXP-1];

    initial begin
        len_mem[0] = '0;
        len_mem[1] = '0;
        foreach (byte_mem[i]) byte_mem[i] = '0;
    end

    function automatic void store_byte(input logic [7:0] b);
        if (rcv_cnt < {2'b00, len_mem[load_sel]} && rcv_cnt < MAXP) begin
            byte_mem[int'(load_sel) * MAXP + int'(rcv_cnt)] = b;
            rcv_cnt = rcv_cnt + 8'd1;
        end else begin
            rcv_cnt = CNT_IDLE;
        end
    endfunction

    // Advances the predicted state by one accepted word and queues the words a fetch returns.
    function automatic void deframe_step(input logic act, input logic [7:0] b);
        logic      found;
        logic      sel;
        int        n;
        pkt_word_t w;
        if (act == ACT_BYTE) begin
            if (b == CODE_END) begin
                if (rcv_cnt == {2'b00, len_mem[load_sel]}) begin
                    if (!cons_holds) begin
                        load_sel  = ~load_sel;
                        pkt_ready = 1'b1;
                        rcv_cnt   = CNT_IDLE;
                    end else begin
                        rcv_cnt = CNT_DONE;
                    end
                end else begin
                    rcv_cnt = CNT_IDLE;
                end
            end else if (b == CODE_ESC) begin
                esc_pend = 1'b1;
            end else if (esc_pend) begin
                esc_pend = 1'b0;
                if (b <= HEAD_LIMIT) begin
                    if (rcv_cnt == CNT_IDLE) begin
                        len_mem[load_sel] = b[5:0];
                        rcv_cnt = 8'd0;
                    end
                end else begin
                    store_byte(b + ESC_OFFSET);
                end
            end else begin
                store_byte(b);
            end
            return;
        end
        found      = 1'b0;
        cons_holds = 1'b0;
        if (pkt_ready) begin
            pkt_ready  = 1'b0;
            cons_holds = 1'b1;
            found      = 1'b1;
        end else if (rcv_cnt == CNT_DONE) begin
            load_sel   = ~load_sel;
            rcv_cnt    = CNT_IDLE;
            cons_holds = 1'b1;
            found      = 1'b1;
        end
        w = '0;
        w.last = 1'b1;
        if (!found) begin
            fetch_word_q.push_back(w);
            return;
        end
        sel = ~load_sel;
        n   = int'(len_mem[sel]);
        w.found = 1'b1;
        if (n == 0) begin
            fetch_word_q.push_back(w);
            return;
        end
        for (int i = 0; i < n; i++) begin
            w.plen  = n[5:0];
            w.pbyte = byte_mem[int'(sel) * MAXP + i];
            w.pidx  = i[5:0];
            w.last  = (i == n - 1);
            fetch_word_q.push_back(w);
        end
    endfunction

    function automatic void add_item(input logic act, input logic [7:0] v,
                                     input logic hold = 1'b0);
        line_item_t it;
        it.act    = act;
        it.rx_val = v;
        it.hold   = hold;
        line_q.push_back(it);
    endfunction

    function automatic void add_fetch(input logic hold = 1'b0);
        add_item(ACT_FETCH, 8'($urandom_range(0, 255)), hold);
    endfunction

    // Payload byte in raw or escaped form, now and then with a doubled escape.
    function automatic void add_payload_byte();
        if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 7) == 0) add_item(ACT_BYTE, CODE_ESC);
            add_item(ACT_BYTE, CODE_ESC);
            add_item(ACT_BYTE, 8'($urandom_range(64, 253)));
        end else begin
            add_item(ACT_BYTE, 8'($urandom_range(0, 253)));
        end
    endfunction

    // A flaw of 1 drops one payload byte, a flaw of 2 adds one past the length.
    function automatic void add_frame(input int len, input int flaw);
        int n;
        n = len;
        if (flaw == 1 && n > 0) n--;
        if (flaw == 2) n++;
        add_item(ACT_BYTE, CODE_ESC);
        add_item(ACT_BYTE, 8'(len));
        for (int i = 0; i < n; i++) add_payload_byte();
        add_item(ACT_BYTE, CODE_END);
    endfunction

    // Sender: bursts of words separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.action  = ACT_BYTE;
        rx_if.rx_byte = '0;
        pkt_if.ready  = 1'b0;
    end

    always @(posedge i_clk) begin : drv_blk
        line_item_t cur;
        logic       show;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                cur = line_q.pop_front();
                deframe_step(cur.act, cur.rx_val);
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            // A presented word stays on the bus until it is taken.
            if (!(rx_if.valid && !rx_if.ready)) begin
                show = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (line_q.size() != 0 && !(line_q[0].hold && fetch_word_q.size() != 0))
                    show = 1'b1;
                rx_if.valid <= show;
                if (show) begin
                    rx_if.action  <= line_q[0].act;
                    rx_if.rx_byte <= line_q[0].rx_val;
                end
            end
        end
    end

    // Receiver: ready follows a 16-bit pattern that is redrawn each time it has been stepped through.
    logic [15:0] stall_pat  = 16'hFFFF;
    logic [3:0]  stall_step = 4'd0;

    always @(posedge i_clk) begin : mon_blk
        pkt_word_t got;
        pkt_word_t want;
        logic      bad;
        if (i_rst_n) begin
            if (pkt_if.valid && pkt_if.ready) begin
                got.found = pkt_if.packet_found;
                got.plen  = pkt_if.packet_length;
                got.pbyte = pkt_if.payload_byte;
                got.pidx  = pkt_if.byte_index;
                got.last  = pkt_if.last;
                if (fetch_word_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"%0t: word with none expected: ",
                                  "found=%0b len=%0d byte=%02h idx=%0d last=%0b"},
                                 $realtime, got.found, got.plen, got.pbyte, got.pidx,
                                 got.last);
                end else begin
                    want = fetch_word_q.pop_front();
                    bad = (got.found !== want.found) || (got.plen !== want.plen) ||
                          (got.pbyte !== want.pbyte) || (got.pidx !== want.pidx) ||
                          (got.last !== want.last);
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display({"%0t: mismatch, expected ",
                                      "found=%0b len=%0d byte=%02h idx=%0d last=%0b"},
                                     $realtime, want.found, want.plen, want.pbyte,
                                     want.pidx, want.last);
                            $display({"%0t:           actual ",
                                      "found=%0b len=%0d byte=%02h idx=%0d last=%0b"},
                                     $realtime, got.found, got.plen, got.pbyte,
                                     got.pidx, got.last);
                        end
                    end
                end
            end
            stall_step = stall_step + 4'd1;
            if (stall_step == 4'd0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0101);
            pkt_if.ready <= stall_pat[stall_step];
        end
    end

    initial begin : stim_blk
        int n_directed;
        int pick;
        int len;
        logic big_done;

        // No packet yet, then an empty frame.
        add_fetch();
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, 8'd0); add_item(ACT_BYTE, CODE_END);
        // A header inside an open frame is ignored; this second frame replaces the unfetched one.
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, 8'd1);
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, 8'd2);
        add_item(ACT_BYTE, 8'hAA);    add_item(ACT_BYTE, CODE_END);
        add_fetch();
        // Double escape, a byte past the length, then a terminator with a wrong count.
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, 8'd2);
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, 8'hFD);
        add_item(ACT_BYTE, 8'h00);    add_item(ACT_BYTE, 8'h01);    add_item(ACT_BYTE, CODE_END);
        // The escape survives the terminator and turns the next byte into a header.
        // The frame finishes while the consumer holds a buffer and is fetched from there.
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, CODE_END);
        add_item(ACT_BYTE, 8'd1);     add_item(ACT_BYTE, 8'h80);    add_item(ACT_BYTE, CODE_END);
        add_fetch();
        // A finished frame waiting for the consumer is lost to a further data byte.
        add_item(ACT_BYTE, CODE_ESC); add_item(ACT_BYTE, 8'd0);     add_item(ACT_BYTE, CODE_END);
        add_item(ACT_BYTE, 8'h7F);
        add_fetch();
        n_directed = line_q.size();

        big_done = 1'b0;
        while (line_q.size() - n_directed < N_RANDOM) begin
            if (!big_done && line_q.size() - n_directed > 100) begin
                // Largest frame, fetched only once the bus has drained.
                add_fetch(1'b1);
                add_frame(MAXP, 0);
                add_fetch(1'b1);
                big_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(10, MAXP) : $urandom_range(0, 8);
            if (pick < 55) begin
                add_frame(len, 0);
                if ($urandom_range(0, 1) == 0) add_fetch($urandom_range(0, 7) == 0);
            end else if (pick < 75) begin
                add_fetch($urandom_range(0, 7) == 0);
            end else if (pick < 87) begin
                add_frame(len, $urandom_range(1, 2));
                add_item(ACT_BYTE, CODE_END);
            end else begin
                repeat ($urandom_range(1, 4)) add_item(ACT_BYTE, 8'($urandom_range(0, 255)));
                add_item(ACT_BYTE, CODE_END);
            end
        end
        add_fetch();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_q.size() != 0 || rx_if.valid) @(posedge i_clk);
        while (fetch_word_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0 && fetch_word_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
